// ===== rtl/v3alu_pkg.sv =====
// ----------------------------------------------------------------------------
// v3alu_pkg
// Shared types and constants for the three-component fixed-point vector unit.
// ----------------------------------------------------------------------------
package v3alu_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int VAL_BITS  = SUM_BITS - FRAC_BITS;
  localparam int QUO_BITS  = FRAC_BITS + 2;
  localparam int LATENCY   = 3 + (WORD_BITS + 1) + 1 + QUO_BITS + 1;

  localparam logic [2:0] CMD_ADD       = 3'd0;
  localparam logic [2:0] CMD_SUB       = 3'd1;
  localparam logic [2:0] CMD_SCALE     = 3'd2;
  localparam logic [2:0] CMD_DOT       = 3'd3;
  localparam logic [2:0] CMD_CROSS     = 3'd4;
  localparam logic [2:0] CMD_NORM      = 3'd5;
  localparam logic [2:0] CMD_NORMALIZE = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [2:0]                  command;
    logic signed [WORD_BITS-1:0] a_x;
    logic signed [WORD_BITS-1:0] a_y;
    logic signed [WORD_BITS-1:0] a_z;
    logic signed [WORD_BITS-1:0] b_x;
    logic signed [WORD_BITS-1:0] b_y;
    logic signed [WORD_BITS-1:0] b_z;
    logic signed [WORD_BITS-1:0] scale;
  } item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] r_x;
    logic signed [WORD_BITS-1:0] r_y;
    logic signed [WORD_BITS-1:0] r_z;
    logic [1:0]                  status;
  } result_t;

endpackage

// ===== rtl/vector3_alu.sv =====
// ----------------------------------------------------------------------------
// vector3_alu
// Pipelined Q16.16 vector unit: add, sub, scale, dot, cross, norm, normalize.
// ----------------------------------------------------------------------------
//  channel   | signals              | transaction
//  ----------+----------------------+------------------------------------
//  command   | start, busy, item    | start high and busy low at clk edge
//  result    | done, result         | one cycle with done high
//
//  One transaction enters per cycle while busy is low; each result appears
//  after its command, in order. The depth is set by the square root (one
//  root bit per stage) followed by the normalize divider (one quotient bit
//  per stage). busy is high only during reset; rst clears the valid bits.
//  The result side cannot stall.
module vector3_alu (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  v3alu_pkg::item_t    item,
  output logic                done,
  output v3alu_pkg::result_t  result
);
  import v3alu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = PROD_BITS;
  localparam int SW = SUM_BITS;
  localparam int VW = VAL_BITS;
  localparam int QB = QUO_BITS;

  localparam logic [SW-1:0] HALF    = {{(SW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic [SW-1:0] HALF_LO = HALF - SW'(1);

  typedef logic signed [W-1:0] word_t;

  typedef struct packed {
    logic                  valid;
    logic [2:0]            cmd;
    logic [5:0][PW-1:0]    prod;
    logic [2:0][W:0]       addv;
    logic [2:0][W-1:0]     amag;
    logic [2:0]            aneg;
  } mul_t;

  typedef struct packed {
    logic                  valid;
    logic [2:0]            cmd;
    logic [2:0][SW-1:0]    v;
    logic [2:0][W:0]       addv;
    logic [2:0][W-1:0]     amag;
    logic [2:0]            aneg;
  } comb_t;

  typedef struct packed {
    logic                  valid;
    logic [2:0]            cmd;
    logic [2:0][VW-1:0]    res;
    logic [2:0][W-1:0]     amag;
    logic [2:0]            aneg;
    logic [PW-1:0]         rad;
    logic [W+1:0]          srem;
    logic [W-1:0]          root;
    logic [W:0]            norm;
    logic [2:0][W:0]       drem;
    logic [2:0][QB-1:0]    dnum;
    logic [2:0][QB-1:0]    quo;
  } pipe_t;

  assign busy = rst;

  // stage 0: input register
  logic  s0_valid;
  item_t s0_item;

  always_ff @(posedge clk) begin
    s0_item <= item;
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
  end

  // stage 1: products, add/sub, magnitudes
  mul_t  s1, s1_next;
  word_t a [3];
  word_t b [3];
  word_t ml [6];
  word_t mr [6];
  logic signed [PW-1:0] prd;

  always_comb begin
    a[0] = s0_item.a_x;
    a[1] = s0_item.a_y;
    a[2] = s0_item.a_z;
    b[0] = s0_item.b_x;
    b[1] = s0_item.b_y;
    b[2] = s0_item.b_z;
    for (int i = 0; i < 6; i++) begin
      ml[i] = '0;
      mr[i] = '0;
    end
    case (s0_item.command) inside
      CMD_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ml[i] = a[i];
          mr[i] = s0_item.scale;
        end
      end
      CMD_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ml[i] = a[i];
          mr[i] = b[i];
        end
      end
      CMD_CROSS: begin
        ml[0] = a[1]; mr[0] = b[2];
        ml[1] = a[2]; mr[1] = b[0];
        ml[2] = a[0]; mr[2] = b[1];
        ml[3] = a[2]; mr[3] = b[1];
        ml[4] = a[0]; mr[4] = b[2];
        ml[5] = a[1]; mr[5] = b[0];
      end
      CMD_NORM, CMD_NORMALIZE: begin
        for (int i = 0; i < 3; i++) begin
          ml[i] = a[i];
          mr[i] = a[i];
        end
      end
      default: ;
    endcase
    s1_next.valid = s0_valid && !rst;
    s1_next.cmd   = s0_item.command;
    for (int i = 0; i < 6; i++) begin
      prd = PW'(ml[i]) * PW'(mr[i]);
      s1_next.prod[i] = prd;
    end
    for (int i = 0; i < 3; i++) begin
      if (s0_item.command == CMD_SUB) begin
        s1_next.addv[i] = {a[i][W-1], a[i]} - {b[i][W-1], b[i]};
      end else begin
        s1_next.addv[i] = {a[i][W-1], a[i]} + {b[i][W-1], b[i]};
      end
      s1_next.aneg[i] = a[i][W-1];
      s1_next.amag[i] = a[i][W-1] ? (~a[i] + 1'b1) : a[i];
    end
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
  end

  // stage 2: sums and differences of products
  comb_t s2, s2_next;
  logic signed [SW-1:0] p [6];
  logic signed [SW-1:0] psum;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      p[i] = {{2{s1.prod[i][PW-1]}}, s1.prod[i]};
    end
    psum = p[0] + p[1] + p[2];
    s2_next.valid = s1.valid && !rst;
    s2_next.cmd   = s1.cmd;
    s2_next.addv  = s1.addv;
    s2_next.amag  = s1.amag;
    s2_next.aneg  = s1.aneg;
    s2_next.v     = '0;
    case (s1.cmd) inside
      CMD_SCALE: begin
        for (int i = 0; i < 3; i++) s2_next.v[i] = p[i];
      end
      CMD_DOT, CMD_NORM, CMD_NORMALIZE: begin
        s2_next.v[0] = psum;
      end
      CMD_CROSS: begin
        for (int i = 0; i < 3; i++) s2_next.v[i] = p[i] - p[i+3];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    s2 <= s2_next;
  end

  // stage 3: rounding, square root set-up
  pipe_t sq [W+1];
  pipe_t sq0_next;
  logic [SW-1:0] rnd [3];

  always_comb begin
    sq0_next       = '0;
    sq0_next.valid = s2.valid && !rst;
    sq0_next.cmd   = s2.cmd;
    sq0_next.amag  = s2.amag;
    sq0_next.aneg  = s2.aneg;
    sq0_next.rad   = s2.v[0][PW-1:0];
    for (int i = 0; i < 3; i++) begin
      rnd[i] = s2.v[i] + (s2.v[i][SW-1] ? HALF_LO : HALF);
      case (s2.cmd) inside
        CMD_ADD, CMD_SUB: sq0_next.res[i] = {{(VW-W-1){s2.addv[i][W]}}, s2.addv[i]};
        CMD_SCALE, CMD_DOT, CMD_CROSS: sq0_next.res[i] = rnd[i][SW-1:F];
        default: sq0_next.res[i] = '0;
      endcase
    end
  end

  // square root: one root bit per stage
  pipe_t        sq_nxt [W];
  logic [W+3:0] sq_acc;
  logic [W+3:0] sq_trial;
  logic [W+3:0] sq_diff;

  always_comb begin
    for (int k = 0; k < W; k++) begin
      sq_nxt[k]       = sq[k];
      sq_nxt[k].valid = sq[k].valid && !rst;
      sq_acc          = {sq[k].srem, sq[k].rad[PW-1 -: 2]};
      sq_trial        = {2'b00, sq[k].root, 2'b01};
      sq_diff         = sq_acc - sq_trial;
      sq_nxt[k].rad   = {sq[k].rad[PW-3:0], 2'b00};
      if (sq_acc >= sq_trial) begin
        sq_nxt[k].srem = sq_diff[W+1:0];
        sq_nxt[k].root = {sq[k].root[W-2:0], 1'b1};
      end else begin
        sq_nxt[k].srem = sq_acc[W+1:0];
        sq_nxt[k].root = {sq[k].root[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    sq[0] <= sq0_next;
    for (int k = 0; k < W; k++) sq[k+1] <= sq_nxt[k];
  end

  // norm rounding, divider set-up
  pipe_t           dv [QB+1];
  pipe_t           dv0_next;
  logic [W:0]      nrm;
  logic [W+F:0]    num [3];

  always_comb begin
    dv0_next = sq[W];
    dv0_next.valid = sq[W].valid && !rst;
    nrm = {1'b0, sq[W].root} + {{W{1'b0}}, (sq[W].srem > {2'b00, sq[W].root})};
    dv0_next.norm = nrm;
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, sq[W].amag[i], {F{1'b0}}} + {{(F+1){1'b0}}, nrm[W:1]};
      dv0_next.drem[i] = {2'b00, num[i][W+F:QB]};
      dv0_next.dnum[i] = num[i][QB-1:0];
      dv0_next.quo[i]  = '0;
    end
  end

  // normalize divider: one quotient bit per stage, all three components
  pipe_t        dv_nxt [QB];
  logic [W+1:0] dv_acc [3];
  logic [W+1:0] dv_diff [3];

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      dv_nxt[k]       = dv[k];
      dv_nxt[k].valid = dv[k].valid && !rst;
      for (int i = 0; i < 3; i++) begin
        dv_acc[i]  = {dv[k].drem[i], dv[k].dnum[i][QB-1]};
        dv_diff[i] = dv_acc[i] - {1'b0, dv[k].norm};
        dv_nxt[k].dnum[i] = {dv[k].dnum[i][QB-2:0], 1'b0};
        if (dv_acc[i] >= {1'b0, dv[k].norm}) begin
          dv_nxt[k].drem[i] = dv_diff[i][W:0];
          dv_nxt[k].quo[i]  = {dv[k].quo[i][QB-2:0], 1'b1};
        end else begin
          dv_nxt[k].drem[i] = dv_acc[i][W:0];
          dv_nxt[k].quo[i]  = {dv[k].quo[i][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dv[0] <= dv0_next;
    for (int k = 0; k < QB; k++) dv[k+1] <= dv_nxt[k];
  end

  // output: select, saturate, register
  pipe_t            fin;
  logic [VW-1:0]    vals [3];
  logic [VW-1:0]    qext [3];
  logic [VW-W:0]    top [3];
  logic [W-1:0]     sat [3];
  logic             ovf;
  logic             zero_len;
  result_t          result_next;

  assign fin = dv[QB];

  always_comb begin
    zero_len = 1'b0;
    ovf      = 1'b0;
    for (int i = 0; i < 3; i++) begin
      vals[i] = '0;
      qext[i] = {{(VW-QB){1'b0}}, fin.quo[i]};
    end
    case (fin.cmd) inside
      CMD_NORM: begin
        vals[0] = {{(VW-W-1){1'b0}}, fin.norm};
      end
      CMD_NORMALIZE: begin
        if (fin.norm == '0) begin
          zero_len = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            vals[i] = fin.aneg[i] ? (~qext[i] + 1'b1) : qext[i];
          end
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) vals[i] = fin.res[i];
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      top[i] = vals[i][VW-1:W-1];
      if ((&top[i]) || !(|top[i])) begin
        sat[i] = vals[i][W-1:0];
      end else begin
        ovf    = 1'b1;
        sat[i] = vals[i][VW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
    end
    result_next.r_x = sat[0];
    result_next.r_y = sat[1];
    result_next.r_z = sat[2];
    if (zero_len) begin
      result_next.status = ST_ZERO;
    end else if (ovf) begin
      result_next.status = ST_OVF;
    end else begin
      result_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
  end

endmodule

// ===== rtl/v3alu_checker.sv =====
// ----------------------------------------------------------------------------
// v3alu_checker
// Port-level checks on the vector unit: fixed latency and result coding.
// ----------------------------------------------------------------------------
module v3alu_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input v3alu_pkg::result_t result
);
  import v3alu_pkg::*;

  // every accepted transaction yields a result after the fixed latency
  a_latency_hit: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after accepted transaction");

  // no result without a matching transaction
  a_latency_miss: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |-> ##LATENCY !done)
    else $error("result without a transaction");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK || result.status == ST_OVF ||
              result.status == ST_ZERO))
    else $error("unknown status code");

  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_ZERO) |->
      (result.r_x == '0 && result.r_y == '0 && result.r_z == '0))
    else $error("zero-length result carries non-zero components");

endmodule

bind vector3_alu v3alu_checker u_checker (.*);
